// ----- rtl/r2fft_pkg.sv -----
// ---------------------------------------------------------------------------
// r2fft_pkg: shared types and constants for the radix-2 FFT engine
// Holds the controller state type, the command struct and the twiddle ROM.
// ---------------------------------------------------------------------------
package r2fft_pkg;

	localparam int RomLog2 = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_WR,
		ST_OUT_RD,
		ST_OUT_SEND
	} state_t;

	localparam logic [0:0] REG_LENGTH  = 1'b0;
	localparam logic [0:0] REG_INVERSE = 1'b1;

	// command from controller to datapath
	typedef struct packed {
		logic       load_we;     // write input sample at addr_a
		logic       rd;          // read both operands
		logic       mul;         // form twiddle products
		logic       wr;          // write butterfly results
		logic       out_rd;      // read bin at addr_a for output
		logic [5:0] addr_a;
		logic [5:0] addr_b;
		logic [5:0] tw_idx;
		logic       inv;
		logic [2:0] shift;       // output shift for inverse mode
	} cmd_t;

	// quarter-wave cosine table, round(32768*cos) with 1.0 saturated
	function automatic logic signed [16:0] quarter_cos(input logic [4:0] k);
		logic signed [16:0] v;
		unique case (k)
			5'd0:  v = 17'sd32767;
			5'd1:  v = 17'sd32610;
			5'd2:  v = 17'sd32138;
			5'd3:  v = 17'sd31357;
			5'd4:  v = 17'sd30274;
			5'd5:  v = 17'sd28899;
			5'd6:  v = 17'sd27246;
			5'd7:  v = 17'sd25330;
			5'd8:  v = 17'sd23170;
			5'd9:  v = 17'sd20788;
			5'd10: v = 17'sd18205;
			5'd11: v = 17'sd15447;
			5'd12: v = 17'sd12540;
			5'd13: v = 17'sd9512;
			5'd14: v = 17'sd6393;
			5'd15: v = 17'sd3212;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [16:0] rom_cos(input logic [5:0] k);
		logic signed [16:0] v;
		if (k <= 6'd16)      v = quarter_cos(5'(k));
		else if (k <= 6'd32) v = -quarter_cos(5'(6'd32 - k));
		else if (k <= 6'd48) v = -quarter_cos(5'(k - 6'd32));
		else                 v = quarter_cos(5'(7'd64 - {1'b0, k}));
		return v;
	endfunction

	function automatic logic signed [16:0] rom_sin(input logic [5:0] k);
		return rom_cos(k + 6'd48);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)       r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else                           r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/radix2_fft_engine_unit.sv -----
// ---------------------------------------------------------------------------
// radix2_fft_engine_unit: in-place radix-2 DIT FFT engine
// Loads N complex Q1.15 samples, runs log2(N) butterfly stages, emits N bins.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one complex sample per beat; tready is high while loading.
//   After the N-th sample the engine computes, then m_axis sends N bins in
//   natural order with tlast on bin N-1. No new samples are taken until the
//   last bin beat is accepted.
//   Each butterfly runs through read, multiply and write states, N/2*log2(N)
//   butterflies in all, set by the single two-port bin memory; then each
//   output bin takes a memory read, then the beat.
//   A stalled receiver holds the current bin on m_axis until taken.
//   APB registers: 0x0 length_log2 (reset 6), 0x4 inverse (reset 0).
//   Reset clears the sequencer and load count; bin memory is not cleared.
// ---------------------------------------------------------------------------
module radix2_fft_engine_unit
	import r2fft_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // sample_re[15:0], sample_im[31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_re[31:0], out_im[63:32]
	output logic        m_axis_tlast
);

	logic [2:0]         length_log2_q;
	logic               inverse_q;
	cmd_t               cmd;
	logic signed [31:0] out_re, out_im;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_log2_q <= 3'd6;
			inverse_q     <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2:2] == REG_LENGTH && paddr[1:0] == 2'd0) begin
			length_log2_q <= pwdata[2:0];
		end else if (psel && penable && pwrite && paddr[2:2] == REG_INVERSE && paddr[1:0] == 2'd0) begin
			inverse_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == 3'd0)      prdata = {29'd0, length_log2_q};
		else if (paddr == 3'd4) prdata = {31'd0, inverse_q};
	end

	r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.length_log2 (length_log2_q),
		.inverse     (inverse_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_last    (m_axis_tlast),
		.cmd         (cmd)
	);

	r2fft_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.sample_re (s_axis_tdata[15:0]),
		.sample_im (s_axis_tdata[31:16]),
		.out_re    (out_re),
		.out_im    (out_im)
	);

	assign m_axis_tdata = {out_im, out_re};

endmodule

// ----- rtl/r2fft_ctrl.sv -----
// ---------------------------------------------------------------------------
// r2fft_ctrl: sequencer for load, butterfly stages and output
// Counts samples, walks stage/group/offset, and drives the output beat.
// ---------------------------------------------------------------------------
module r2fft_ctrl
	import r2fft_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] length_log2,
	input  logic       inverse,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_last,
	output cmd_t       cmd
);

	// log2 of the largest power of two not above MAX_POINTS
	localparam int MaxLg = $clog2(MAX_POINTS + 1) - 1;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;        // load count or output index
	logic [2:0] stage_q, stage_d;    // hl, group size 2^hl
	logic [5:0] bf_q, bf_d;          // butterfly number within stage
	logic [2:0] lg_q, lg_d;          // length latched at transform start
	logic [2:0] lg_eff;
	logic [5:0] nmask, half, kmask, k_off, base, rev;
	logic [5:0] bf_last;

	// effective length: clamp to 1..6 and to MAX_POINTS
	always_comb begin
		lg_eff = length_log2;
		if (lg_eff < 3'd1) lg_eff = 3'd1;
		if (lg_eff > 3'd6) lg_eff = 3'd6;
		if (lg_eff > 3'(MaxLg)) lg_eff = 3'(MaxLg);
	end

	// bit reversal of the load count over lg_eff bits
	always_comb begin
		rev = '0;
		for (int i = 0; i < 6; i++) begin
			if (i < int'(lg_eff)) rev[int'(lg_eff) - 1 - i] = cnt_q[i];
		end
	end

	// butterfly addressing
	always_comb begin
		nmask   = 6'((7'd1 << lg_q) - 7'd1);
		half    = 6'(7'd1 << (stage_q - 3'd1));
		kmask   = half - 6'd1;
		k_off   = bf_q & kmask;
		base    = (bf_q & ~kmask) << 1;
		bf_last = nmask >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			stage_q <= 3'd1;
			bf_q    <= '0;
			lg_q    <= 3'd1;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			stage_q <= stage_d;
			bf_q    <= bf_d;
			lg_q    <= lg_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		stage_d   = stage_q;
		bf_d      = bf_q;
		lg_d      = lg_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		cmd        = '0;
		cmd.inv    = inverse;
		cmd.shift  = inverse ? lg_q : 3'd0;
		cmd.addr_a = base + k_off;
		cmd.addr_b = base + k_off + half;
		cmd.tw_idx = 6'(k_off << (3'(RomLog2) - stage_q));
		unique case (state_q)
			ST_LOAD: begin
				in_ready    = 1'b1;
				cmd.addr_a  = rev;
				cmd.load_we = in_valid;
				if (in_valid) begin
					if (7'({1'b0, cnt_q} + 7'd1) >= (7'd1 << lg_eff)) begin
						cnt_d   = '0;
						lg_d    = lg_eff;
						stage_d = 3'd1;
						bf_d    = '0;
						state_d = ST_BF_RD;
					end else begin
						cnt_d = cnt_q + 6'd1;
					end
				end
			end
			ST_BF_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_BF_MUL;
			end
			ST_BF_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_BF_WR;
			end
			ST_BF_WR: begin
				cmd.wr = 1'b1;
				if (bf_q == bf_last) begin
					bf_d = '0;
					if (stage_q == lg_q) begin
						cnt_d   = '0;
						state_d = ST_OUT_RD;
					end else begin
						stage_d = stage_q + 3'd1;
						state_d = ST_BF_RD;
					end
				end else begin
					bf_d    = bf_q + 6'd1;
					state_d = ST_BF_RD;
				end
			end
			ST_OUT_RD: begin
				cmd.addr_a = cnt_q;
				cmd.out_rd = 1'b1;
				state_d    = ST_OUT_SEND;
			end
			ST_OUT_SEND: begin
				out_valid = 1'b1;
				out_last  = (cnt_q == nmask);
				if (out_ready) begin
					if (cnt_q == nmask) begin
						cnt_d   = '0;
						state_d = ST_LOAD;
					end else begin
						cnt_d   = cnt_q + 6'd1;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

// ----- rtl/r2fft_datapath.sv -----
// ---------------------------------------------------------------------------
// r2fft_datapath: bin memory, twiddle multiply and butterfly add/subtract
// Two-port bin memory with registered reads; one butterfly at a time, read, multiply, write.
// ---------------------------------------------------------------------------
module r2fft_datapath
	import r2fft_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  cmd_t               cmd,
	input  logic signed [15:0] sample_re,
	input  logic signed [15:0] sample_im,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im
);

	localparam int Aw = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

	logic signed [31:0] mem_re [MAX_POINTS];
	logic signed [31:0] mem_im [MAX_POINTS];

	logic signed [31:0] ur_q, ui_q, xr_q, xi_q;
	logic signed [49:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic signed [16:0] wr, wi;
	logic signed [50:0] sum_r, sum_i;
	logic signed [35:0] tr_full, ti_full;
	logic signed [31:0] tr, ti;
	logic signed [31:0] ar, ai, br, bi;
	logic [Aw-1:0]      wa_a, wa_b;

	assign wa_a = cmd.addr_a[Aw-1:0];
	assign wa_b = cmd.addr_b[Aw-1:0];

	// twiddle for this butterfly
	always_comb begin
		wr = rom_cos(cmd.tw_idx);
		wi = cmd.inv ? rom_sin(cmd.tw_idx) : -rom_sin(cmd.tw_idx);
	end

	// operand read and output read
	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.out_rd) begin
			ur_q <= mem_re[wa_a];
			ui_q <= mem_im[wa_a];
		end
		if (cmd.rd) begin
			xr_q <= mem_re[wa_b];
			xi_q <= mem_im[wa_b];
		end
	end

	// partial products, registered
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_rr_q <= 50'(wr * xr_q);
			p_ii_q <= 50'(wi * xi_q);
			p_ri_q <= 50'(wr * xi_q);
			p_ir_q <= 50'(wi * xr_q);
		end
	end

	// round, saturate, add and subtract
	always_comb begin
		sum_r   = 51'(p_rr_q) - 51'(p_ii_q) + 51'sd16384;
		sum_i   = 51'(p_ri_q) + 51'(p_ir_q) + 51'sd16384;
		tr_full = 36'(sum_r >>> 15);
		ti_full = 36'(sum_i >>> 15);
		tr      = sat32(34'(tr_full > 36'sd2147483647 ? 36'sd2147483648 :
		                     (tr_full < -36'sd2147483648 ? -36'sd2147483649 : tr_full)));
		ti      = sat32(34'(ti_full > 36'sd2147483647 ? 36'sd2147483648 :
		                     (ti_full < -36'sd2147483648 ? -36'sd2147483649 : ti_full)));
		ar      = sat32(34'(ur_q) + 34'(tr));
		ai      = sat32(34'(ui_q) + 34'(ti));
		br      = sat32(34'(ur_q) - 34'(tr));
		bi      = sat32(34'(ui_q) - 34'(ti));
	end

	// memory writes: port A takes samples or the sum, port B the difference
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			mem_re[wa_a] <= 32'(sample_re);
			mem_im[wa_a] <= 32'(sample_im);
		end else if (cmd.wr) begin
			mem_re[wa_a] <= ar;
			mem_im[wa_a] <= ai;
		end
		if (cmd.wr) begin
			mem_re[wa_b] <= br;
			mem_im[wa_b] <= bi;
		end
	end

	// inverse scaling on the way out, flooring shift
	assign out_re = ur_q >>> cmd.shift;
	assign out_im = ui_q >>> cmd.shift;

endmodule
